// File: sv/chacha20_stream_cipher_core_macros.svh
// assertion macros for the chacha20 stream cipher core
`ifndef CHACHA20_STREAM_CIPHER_CORE_MACROS_SVH
`define CHACHA20_STREAM_CIPHER_CORE_MACROS_SVH

// implication checked on every clock edge outside reset
`define CC_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// implication whose consequent is checked in the following cycle
`define CC_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: sv/cc20_pkg.sv
// shared types and constants for the chacha20 stream cipher core
package cc20_pkg;

  localparam logic [31:0] SIGMA0 = 32'h61707865;
  localparam logic [31:0] SIGMA1 = 32'h3320646e;
  localparam logic [31:0] SIGMA2 = 32'h79622d32;
  localparam logic [31:0] SIGMA3 = 32'h6b206574;

  localparam logic [2:0] REG_KEY_A    = 3'd0;
  localparam logic [2:0] REG_KEY_B    = 3'd1;
  localparam logic [2:0] REG_KEY_C    = 3'd2;
  localparam logic [2:0] REG_KEY_D    = 3'd3;
  localparam logic [2:0] REG_INIT_CTR = 3'd4;
  localparam logic [2:0] REG_NONCE_LO = 3'd5;
  localparam logic [2:0] REG_NONCE_HI = 3'd6;

  // classified item handed from front to back
  typedef struct packed {
    logic [7:0] data;
    logic       new_block;
    logic       restart;
    logic [5:0] pos;
  } cc20_item_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_ROUND,
    ST_FINAL,
    ST_XOR
  } cc20_state_t;

  function automatic logic [31:0] rotl(input logic [31:0] v, input int unsigned n);
    rotl = (v << n) | (v >> (32 - n));
  endfunction

endpackage

// File: sv/cc20_front.sv
// front end: accepts bytes, tracks byte position and tags block starts
module cc20_front
  import cc20_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_push,
  output logic       in_full,
  input  logic [7:0] in_data_in,
  input  logic       in_first_of_message,
  output logic       q_valid,
  output cc20_item_t q_item,
  input  logic       q_pop
);

  localparam int QD = 2;

  cc20_item_t  q_r [QD];
  cc20_item_t  q_nxt [QD];
  logic        wp_r, wp_nxt, rp_r, rp_nxt;
  logic [1:0]  cnt_r, cnt_nxt;
  logic [5:0]  pos_r, pos_nxt;
  logic        push_ok;
  logic [5:0]  pos_use;
  cc20_item_t  new_item;

  assign in_full = (cnt_r == 2'(QD));
  assign push_ok = in_push && !in_full;
  assign pos_use = in_first_of_message ? 6'd0 : pos_r;
  assign q_valid = (cnt_r != 2'd0);
  assign q_item  = q_r[rp_r];

  always_comb begin
    new_item.data      = in_data_in;
    new_item.new_block = (pos_use == 6'd0);
    new_item.restart   = in_first_of_message;
    new_item.pos       = pos_use;
    q_nxt   = q_r;
    wp_nxt  = wp_r;
    rp_nxt  = rp_r;
    cnt_nxt = cnt_r;
    pos_nxt = pos_r;
    if (push_ok) begin
      q_nxt[wp_r] = new_item;
      wp_nxt      = ~wp_r;
      pos_nxt     = pos_use + 6'd1;
    end
    if (q_pop && q_valid) rp_nxt = ~rp_r;
    cnt_nxt = cnt_r + {1'b0, push_ok} - {1'b0, q_pop && q_valid};
  end

  always_ff @(posedge clk) begin
    q_r <= q_nxt;
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
      pos_r <= 6'd0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
      pos_r <= pos_nxt;
    end
  end

`include "chacha20_stream_cipher_core_macros.svh"
  `CC_ASSERT_IMP(a_no_overfill, cnt_r == 2'(QD), !push_ok, "front queue overfilled")
  `CC_ASSERT_NXT(a_pos_step, push_ok, pos_r == $past(pos_use) + 6'd1, "byte position slip")
  `CC_ASSERT_IMP(a_cnt_range, 1'b1, cnt_r <= 2'(QD), "front queue count out of range")

endmodule

// File: sv/cc20_back.sv
// back end: block generation with one shared quarter-round unit and byte xor
module cc20_back
  import cc20_pkg::*;
#(
  parameter int ROUNDS = 20
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        q_valid,
  input  cc20_item_t  q_item,
  output logic        q_pop,
  input  logic [63:0] key_a,
  input  logic [63:0] key_b,
  input  logic [63:0] key_c,
  input  logic [63:0] key_d,
  input  logic [31:0] init_ctr,
  input  logic [63:0] nonce_lo,
  input  logic [31:0] nonce_hi,
  output logic        out_empty,
  input  logic        out_pop,
  output logic [7:0]  out_data_out
);

  // each double round is eight quarter-round steps
  localparam int NSTEP = ((ROUNDS + 1) / 2) * 8;
  localparam int SW    = $clog2(NSTEP + 1);

  cc20_state_t state_r, state_nxt;
  logic [31:0] ws_r [16];
  logic [31:0] mx_r [16];
  logic [31:0] mx_nxt [16];
  logic [31:0] ctr_r, ctr_nxt;
  logic [SW-1:0] step_r, step_nxt;
  cc20_item_t  cur_r;
  logic [7:0]  od_r;
  logic        ov_r;
  logic        take, out_take, load_ws, do_xor;
  logic [3:0]  ia, ib, ic, id;
  logic [31:0] qa, qb, qc, qd;
  logic [2:0]  sel;

  assign out_empty    = !ov_r;
  assign out_data_out = od_r;
  assign out_take     = out_pop && ov_r;
  assign take         = (state_r == ST_IDLE) && q_valid;
  assign q_pop        = take;

  always_comb begin
    state_nxt = state_r;
    step_nxt  = step_r;
    case (state_r)
      ST_IDLE:  if (q_valid) state_nxt = q_item.new_block ? ST_ROUND : ST_XOR;
      ST_ROUND: begin
        step_nxt = step_r + 1'b1;
        if (step_r == SW'(NSTEP - 1)) state_nxt = ST_FINAL;
      end
      ST_FINAL: state_nxt = ST_XOR;
      ST_XOR:   if (!ov_r || out_take) state_nxt = ST_IDLE;
      default:  state_nxt = ST_IDLE;
    endcase
    if (state_r == ST_IDLE) step_nxt = '0;
  end

  always_comb begin
    load_ws = (state_r == ST_IDLE) && q_valid && q_item.new_block;
    do_xor  = (state_r == ST_XOR) && (!ov_r || out_take);
  end

  // quarter-round operand selection: columns then diagonals
  always_comb begin
    sel = step_r[2:0];
    case (sel)
      3'd0: begin ia = 4'd0; ib = 4'd4; ic = 4'd8;  id = 4'd12; end
      3'd1: begin ia = 4'd1; ib = 4'd5; ic = 4'd9;  id = 4'd13; end
      3'd2: begin ia = 4'd2; ib = 4'd6; ic = 4'd10; id = 4'd14; end
      3'd3: begin ia = 4'd3; ib = 4'd7; ic = 4'd11; id = 4'd15; end
      3'd4: begin ia = 4'd0; ib = 4'd5; ic = 4'd10; id = 4'd15; end
      3'd5: begin ia = 4'd1; ib = 4'd6; ic = 4'd11; id = 4'd12; end
      3'd6: begin ia = 4'd2; ib = 4'd7; ic = 4'd8;  id = 4'd13; end
      3'd7: begin ia = 4'd3; ib = 4'd4; ic = 4'd9;  id = 4'd14; end
      default: begin ia = 4'd0; ib = 4'd4; ic = 4'd8; id = 4'd12; end
    endcase
    qa = mx_r[ia] + mx_r[ib];
    qd = rotl(mx_r[id] ^ qa, 16);
    qc = mx_r[ic] + qd;
    qb = rotl(mx_r[ib] ^ qc, 12);
    qa = qa + qb;
    qd = rotl(qd ^ qa, 8);
    qc = qc + qd;
    qb = rotl(qb ^ qc, 7);
    mx_nxt = mx_r;
    mx_nxt[ia] = qa;
    mx_nxt[ib] = qb;
    mx_nxt[ic] = qc;
    mx_nxt[id] = qd;
  end

  always_comb begin
    ctr_nxt = ctr_r;
    if (state_r == ST_FINAL) ctr_nxt = ws_r[12] + 32'd1;
    else if (do_xor && cur_r.restart && !cur_r.new_block) ctr_nxt = init_ctr;
  end

  always_ff @(posedge clk) begin
    if (take) cur_r <= q_item;
    if (state_r == ST_ROUND) mx_r <= mx_nxt;
    // add-back leaves the keystream words in the mix registers until the next block
    if (state_r == ST_FINAL) begin
      for (int i = 0; i < 16; i++) begin
        mx_r[i] <= mx_r[i] + ws_r[i];
      end
    end
    if (do_xor) od_r <= cur_r.data ^ mx_r[cur_r.pos[5:2]][{cur_r.pos[1:0], 3'b000} +: 8];
    if (load_ws) begin
      ws_r[0]  <= SIGMA0;          mx_r[0]  <= SIGMA0;
      ws_r[1]  <= SIGMA1;          mx_r[1]  <= SIGMA1;
      ws_r[2]  <= SIGMA2;          mx_r[2]  <= SIGMA2;
      ws_r[3]  <= SIGMA3;          mx_r[3]  <= SIGMA3;
      ws_r[4]  <= key_a[31:0];     mx_r[4]  <= key_a[31:0];
      ws_r[5]  <= key_a[63:32];    mx_r[5]  <= key_a[63:32];
      ws_r[6]  <= key_b[31:0];     mx_r[6]  <= key_b[31:0];
      ws_r[7]  <= key_b[63:32];    mx_r[7]  <= key_b[63:32];
      ws_r[8]  <= key_c[31:0];     mx_r[8]  <= key_c[31:0];
      ws_r[9]  <= key_c[63:32];    mx_r[9]  <= key_c[63:32];
      ws_r[10] <= key_d[31:0];     mx_r[10] <= key_d[31:0];
      ws_r[11] <= key_d[63:32];    mx_r[11] <= key_d[63:32];
      ws_r[12] <= q_item.restart ? init_ctr : ctr_r;
      mx_r[12] <= q_item.restart ? init_ctr : ctr_r;
      ws_r[13] <= nonce_lo[31:0];  mx_r[13] <= nonce_lo[31:0];
      ws_r[14] <= nonce_lo[63:32]; mx_r[14] <= nonce_lo[63:32];
      ws_r[15] <= nonce_hi;        mx_r[15] <= nonce_hi;
    end
    if (!rst_n) begin
      state_r <= ST_IDLE;
      step_r  <= '0;
      ctr_r   <= '0;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      step_r  <= step_nxt;
      ctr_r   <= ctr_nxt;
      if (do_xor) ov_r <= 1'b1;
      else if (out_take) ov_r <= 1'b0;
    end
  end

`include "chacha20_stream_cipher_core_macros.svh"
  `CC_ASSERT_IMP(a_pop_idle, q_pop, state_r == ST_IDLE, "queue popped while busy")
  `CC_ASSERT_NXT(a_final_once, state_r == ST_FINAL, state_r == ST_XOR,
                 "final add not followed by xor")
  `CC_ASSERT_NXT(a_ctr_bump, state_r == ST_FINAL, ctr_r == $past(ws_r[12]) + 32'd1,
                 "block counter did not advance")

endmodule

// File: sv/chacha20_stream_cipher_core.sv
// chacha20 stream cipher core top level
// Byte-stream ChaCha20 (RFC 7539): each pushed byte comes back XORed with the
// next keystream byte. A byte at block position 0 (or flagged first of message)
// starts a new 64-byte keystream block, generated by one shared quarter-round
// unit through load, rounds, add-back and xor in turn; other bytes go straight
// to the xor in the back end. A two-entry input queue lets bytes be pushed
// while a block is generated. Configuration written between blocks applies to
// the next block.
module chacha20_stream_cipher_core
  import cc20_pkg::*;
#(
  parameter int ROUNDS = 20
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        push,
  output logic        full,
  input  logic [7:0]  in_data_in,
  input  logic        in_first_of_message,
  output logic        empty,
  input  logic        pop,
  output logic [7:0]  out_data_out,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [63:0] cfg_data
);

  logic [63:0] key_a_r, key_b_r, key_c_r, key_d_r, nonce_lo_r;
  logic [31:0] init_ctr_r, nonce_hi_r;
  logic        q_valid, q_pop;
  cc20_item_t  q_item;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_a_r <= '0; key_b_r <= '0; key_c_r <= '0; key_d_r <= '0;
      init_ctr_r <= '0; nonce_lo_r <= '0; nonce_hi_r <= '0;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_KEY_A:    key_a_r    <= cfg_data;
        REG_KEY_B:    key_b_r    <= cfg_data;
        REG_KEY_C:    key_c_r    <= cfg_data;
        REG_KEY_D:    key_d_r    <= cfg_data;
        REG_INIT_CTR: init_ctr_r <= cfg_data[31:0];
        REG_NONCE_LO: nonce_lo_r <= cfg_data;
        REG_NONCE_HI: nonce_hi_r <= cfg_data[31:0];
        default: ;
      endcase
    end
  end

  cc20_front u_front (
    .clk, .rst_n, .in_push(push), .in_full(full), .in_data_in, .in_first_of_message,
    .q_valid, .q_item, .q_pop
  );

  cc20_back #(.ROUNDS(ROUNDS)) u_back (
    .clk, .rst_n, .q_valid, .q_item, .q_pop,
    .key_a(key_a_r), .key_b(key_b_r), .key_c(key_c_r), .key_d(key_d_r),
    .init_ctr(init_ctr_r), .nonce_lo(nonce_lo_r), .nonce_hi(nonce_hi_r),
    .out_empty(empty), .out_pop(pop), .out_data_out
  );

endmodule
